// ===== rtl/mppq_pkg.sv =====
// ----------------------------------------------------------------------------
// mppq_pkg
// Shared types and constants for the PS/2 mouse packet cursor queue.
// ----------------------------------------------------------------------------
package mppq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  // input item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_SCALE  = 2'd3;

  localparam logic [7:0]  SYNC_BIT      = 8'h08;
  localparam logic [7:0]  OVERFLOW_BITS = 8'hC0;
  localparam int          X_SIGN_POS    = 4;
  localparam int          Y_SIGN_POS    = 5;
  localparam logic [13:0] DEFAULT_WIDTH  = 14'd1024;
  localparam logic [13:0] DEFAULT_HEIGHT = 14'd768;
  localparam logic [13:0] MAX_SCREEN     = 14'd8192;
  localparam logic [4:0]  SCALE_RESET    = 5'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [12:0] set_x;
    logic [12:0] set_y;
  } in_item_t;

  typedef struct packed {
    logic        report_valid;
    logic [12:0] cursor_x;
    logic [12:0] cursor_y;
    logic [2:0]  buttons;
    logic [31:0] packet_count;
    logic [31:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [2:0]  buttons;
  } qent_t;

  // dequeue event handed from the decoder to the result pipeline
  typedef struct packed {
    logic        fire;
    logic        report_valid;
    logic [31:0] packet_count;
    logic [31:0] byte_count;
  } deq_info_t;

endpackage

// ===== rtl/mppq_ram.sv =====
// ----------------------------------------------------------------------------
// mppq_ram
// Report queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mppq_ram
  import mppq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  qent_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output qent_t         rd_data
);

  qent_t mem [DEPTH];
  qent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mppq_decode.sv =====
// ----------------------------------------------------------------------------
// mppq_decode
// Packet assembly, cursor update, queue pointers, counters and config regs.
// ----------------------------------------------------------------------------
module mppq_decode
  import mppq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [13:0]   cfg_data,
  input  logic          accept,
  input  in_item_t      item,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output qent_t         wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output deq_info_t     deq
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic        enable_r;
  logic [13:0] width_r, height_r;
  logic [4:0]  scale_r;

  logic [1:0]  held_r, held_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [7:0]  xb_r, xb_nxt;
  logic [12:0] abs_x_r, abs_x_nxt;
  logic [12:0] abs_y_r, abs_y_nxt;
  logic        known_r, known_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [31:0] pkt_r, pkt_nxt;
  logic [31:0] byte_r, byte_nxt;

  logic [13:0] sw, sh;
  logic [12:0] base_x, base_y;
  logic signed [8:0]  dx, dy;
  logic signed [5:0]  sc;
  logic signed [14:0] prod_x, prod_y;
  logic signed [15:0] sum_x, sum_y;
  logic [12:0] new_x, new_y;
  logic [AW-1:0] wptr_inc, rptr_inc;
  logic        full, empty, push, pop;

  function automatic logic [13:0] screen_dim(input logic [13:0] r, input logic [13:0] dflt);
    logic [13:0] d;
    if (r == 14'd0) begin
      d = dflt;
    end else if (r > MAX_SCREEN) begin
      d = MAX_SCREEN;
    end else begin
      d = r;
    end
    return d;
  endfunction

  function automatic logic [12:0] clamp(input logic signed [15:0] v, input logic [13:0] dim);
    logic [13:0] mx;
    logic [12:0] c;
    mx = dim - 14'd1;
    if (v < 0) begin
      c = 13'd0;
    end else if (v > $signed({2'b00, mx})) begin
      c = mx[12:0];
    end else begin
      c = v[12:0];
    end
    return c;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      width_r  <= 14'd0;
      height_r <= 14'd0;
      scale_r  <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_SCALE:  scale_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // cursor arithmetic for the packet that completes with this byte
  always_comb begin
    sw     = screen_dim(width_r, DEFAULT_WIDTH);
    sh     = screen_dim(height_r, DEFAULT_HEIGHT);
    base_x = known_r ? abs_x_r : sw[13:1];
    base_y = known_r ? abs_y_r : sh[13:1];
    dx     = $signed({hdr_r[X_SIGN_POS], xb_r});
    dy     = $signed({hdr_r[Y_SIGN_POS], item.byte_value});
    sc     = $signed({1'b0, scale_r});
    prod_x = dx * sc;
    prod_y = dy * sc;
    sum_x  = $signed({3'b000, base_x}) + 16'(prod_x);
    sum_y  = $signed({3'b000, base_y}) - 16'(prod_y);
    new_x  = clamp(sum_x, sw);
    new_y  = clamp(sum_y, sh);
  end

  assign wptr_inc = (wptr_r == LAST_SLOT) ? '0 : wptr_r + AW'(1);
  assign rptr_inc = (rptr_r == LAST_SLOT) ? '0 : rptr_r + AW'(1);
  assign full     = (wptr_inc == rptr_r);
  assign empty    = (wptr_r == rptr_r);

  always_comb begin
    held_nxt  = held_r;
    hdr_nxt   = hdr_r;
    xb_nxt    = xb_r;
    abs_x_nxt = abs_x_r;
    abs_y_nxt = abs_y_r;
    known_nxt = known_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    pkt_nxt   = pkt_r;
    byte_nxt  = byte_r;
    push      = 1'b0;
    pop       = 1'b0;
    deq       = '0;
    if (accept) begin
      unique case (item.kind)
        KIND_BYTE: begin
          byte_nxt = byte_r + 32'd1;
          if (enable_r) begin
            priority case (held_r)
              2'd0: begin
                if ((item.byte_value & SYNC_BIT) != 8'd0) begin
                  hdr_nxt  = item.byte_value;
                  held_nxt = 2'd1;
                end
              end
              2'd1: begin
                xb_nxt   = item.byte_value;
                held_nxt = 2'd2;
              end
              default: begin
                held_nxt = 2'd0;
                // drop on overflow or a full queue
                if ((hdr_r & OVERFLOW_BITS) == 8'd0 && !full) begin
                  push      = 1'b1;
                  abs_x_nxt = new_x;
                  abs_y_nxt = new_y;
                  known_nxt = 1'b1;
                  wptr_nxt  = wptr_inc;
                  pkt_nxt   = pkt_r + 32'd1;
                end
              end
            endcase
          end
        end
        KIND_DEQ: begin
          pop              = enable_r && !empty;
          deq.fire         = 1'b1;
          deq.report_valid = pop;
          deq.packet_count = pkt_r;
          deq.byte_count   = byte_r;
          if (pop) begin
            rptr_nxt = rptr_inc;
          end
        end
        KIND_SET: begin
          abs_x_nxt = item.set_x;
          abs_y_nxt = item.set_y;
          known_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 2'd0;
      hdr_r   <= 8'd0;
      xb_r    <= 8'd0;
      abs_x_r <= 13'd0;
      abs_y_r <= 13'd0;
      known_r <= 1'b0;
      rptr_r  <= '0;
      wptr_r  <= '0;
      pkt_r   <= 32'd0;
      byte_r  <= 32'd0;
    end else begin
      held_r  <= held_nxt;
      hdr_r   <= hdr_nxt;
      xb_r    <= xb_nxt;
      abs_x_r <= abs_x_nxt;
      abs_y_r <= abs_y_nxt;
      known_r <= known_nxt;
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      pkt_r   <= pkt_nxt;
      byte_r  <= byte_nxt;
    end
  end

  assign wr_en           = push;
  assign wr_addr         = wptr_r;
  assign wr_data.x       = new_x;
  assign wr_data.y       = new_y;
  assign wr_data.buttons = hdr_r[2:0];
  assign rd_en           = pop;
  assign rd_addr         = rptr_r;

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("queue read and write hit the same entry");

  a_pkt_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> pkt_r == $past(pkt_r) + 32'd1)
    else $error("packet count did not follow a push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> enable_r && (rptr_r != wptr_r))
    else $error("dequeue from an empty or disabled queue");

endmodule

// ===== rtl/ps2_mouse_packet_cursor_queue_core.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_queue_core
// PS/2 mouse 3-byte packet decoder with clamped cursor and report queue.
// ----------------------------------------------------------------------------
// channel  ports                         direction  handshake
// in       in_valid/in_ready/in_data     input      valid/ready
// out      out_valid/out_ready/out_data  output     valid/ready
// cfg      cfg_we/cfg_index/cfg_data     input      write strobe
//
// One item is accepted per cycle while in_ready is high; bytes and cursor sets
// update state at the accept edge. A dequeue result reaches out_data in two
// registered steps: the queue memory is read at the accept edge, and the output
// register loads the read data and staged counters once it is free to take them.
// A stalled result holds the output register and one staged dequeue behind
// it; input is held off only when both are occupied.
// Reset is synchronous, active low; the queue memory is not cleared.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_queue_core
  import mppq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  qent_t         wr_data, rd_data;
  deq_info_t     deq;

  logic      p1_valid_r, p1_valid_nxt;
  deq_info_t p1_info_r;
  logic      p1_move;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  assign in_ready = !p1_valid_r || !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign p1_move  = p1_valid_r && (!out_valid_r || out_ready);

  mppq_decode #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .deq      (deq)
  );

  mppq_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    p1_valid_nxt = deq.fire || (p1_valid_r && !p1_move);
    if (p1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage the counters alongside the memory read
  always_ff @(posedge clk) begin
    if (deq.fire) begin
      p1_info_r <= deq;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_data_r.report_valid <= p1_info_r.report_valid;
      out_data_r.cursor_x     <= p1_info_r.report_valid ? rd_data.x : 13'd0;
      out_data_r.cursor_y     <= p1_info_r.report_valid ? rd_data.y : 13'd0;
      out_data_r.buttons      <= p1_info_r.report_valid ? rd_data.buttons : 3'd0;
      out_data_r.packet_count <= p1_info_r.packet_count;
      out_data_r.byte_count   <= p1_info_r.byte_count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && !p1_move |=> p1_valid_r)
    else $error("staged dequeue lost while output stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    deq.fire |-> !p1_valid_r || p1_move)
    else $error("dequeue accepted into an occupied stage");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.report_valid |->
      out_data_r.cursor_x == 13'd0 && out_data_r.cursor_y == 13'd0 &&
      out_data_r.buttons == 3'd0)
    else $error("empty report carries nonzero fields");

endmodule
